/* rtl/core/hsv_pkg.sv */
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, constants and stage word types for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

   localparam int IN_W     = 10;
   localparam int OUT_W    = 8;
   localparam int CHROMA_W = 20;
   localparam int TRI_W    = 8;
   localparam int SECTOR_W = 3;

   // hue period and sector length
   localparam logic [IN_W-1:0] HUE_SPAN   = 10'd768;
   localparam int              SECTOR_SH  = 7;   // log2 of 128 steps per sector
   localparam int              VAL_SH     = 10;  // value * 1024
   localparam int              OUT_SH     = 12;  // sum / 4096

   // sector codes
   localparam logic [SECTOR_W-1:0] SECTOR_RED_UP    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_LO  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_UP  = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_LO   = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_UP   = 3'd4;

   typedef struct packed {
      logic [IN_W-1:0] hue_raw;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [TRI_W-1:0]    tri_w;
      logic [CHROMA_W-1:0] chroma;
      logic [IN_W-1:0]     val;
   } front_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [CHROMA_W-1:0] second;
      logic [CHROMA_W-1:0] chroma;
      logic [CHROMA_W-1:0] offset;
   } mix_type;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

/* rtl/core/hsv_front.sv */
// ----------------------------------------------------------------------------
// hsv_front
// Stage one: hue wrap, sector and triangle weight, chroma = value * saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hsv_pkg::hsv_type in_word,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output hsv_pkg::front_type    out_word
);
   import hsv_pkg::*;

   logic            valid_ff;
   front_type       word_ff;
   front_type       word_in;
   logic [IN_W-1:0] hue;
   logic [7:0]      pos;
   logic [8:0]      mirror;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      hue = (in_word.hue_raw >= HUE_SPAN) ? in_word.hue_raw - HUE_SPAN : in_word.hue_raw;
      pos = hue[7:0];
      // rising half: pos; falling half: 256 - pos
      mirror = 9'd256 - {1'b0, pos};
      word_in.sector = hue[IN_W-1:SECTOR_SH];
      word_in.tri_w  = pos[7] ? mirror[TRI_W-1:0] : pos;
      word_in.chroma = CHROMA_W'(in_word.brightness * in_word.saturation);
      word_in.val    = in_word.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

/* rtl/core/hsv_mix.sv */
// ----------------------------------------------------------------------------
// hsv_mix
// Stage two: secondary term = chroma * weight / 128, offset = value*1024 - chroma.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_mix (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire hsv_pkg::front_type in_word,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output hsv_pkg::mix_type        out_word
);
   import hsv_pkg::*;

   localparam int PROD_W = CHROMA_W + TRI_W;

   logic                valid_ff;
   mix_type             word_ff;
   mix_type             word_in;
   logic [PROD_W-1:0]   prod;
   logic [CHROMA_W-1:0] scaled_val;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod       = in_word.chroma * in_word.tri_w;
      scaled_val = {in_word.val, {VAL_SH{1'b0}}};
      word_in.sector = in_word.sector;
      // weight tops out at 128, so the quotient never exceeds chroma
      word_in.second = prod[SECTOR_SH +: CHROMA_W];
      word_in.chroma = in_word.chroma;
      word_in.offset = scaled_val - in_word.chroma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

/* rtl/core/hsv_out.sv */
// ----------------------------------------------------------------------------
// hsv_out
// Stage three: sector routing, offset add and scale down to 8-bit channels.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_out (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hsv_pkg::mix_type in_word,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output hsv_pkg::rgb_type      out_word
);
   import hsv_pkg::*;

   logic                valid_ff;
   rgb_type             word_ff;
   rgb_type             word_in;
   logic [CHROMA_W-1:0] r_raw;
   logic [CHROMA_W-1:0] g_raw;
   logic [CHROMA_W-1:0] b_raw;
   logic [CHROMA_W:0]   r_sum;
   logic [CHROMA_W:0]   g_sum;
   logic [CHROMA_W:0]   b_sum;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      r_raw = '0;
      g_raw = '0;
      b_raw = '0;
      case (in_word.sector)
         SECTOR_RED_UP: begin
            r_raw = in_word.chroma;
            g_raw = in_word.second;
         end
         SECTOR_GREEN_LO: begin
            r_raw = in_word.second;
            g_raw = in_word.chroma;
         end
         SECTOR_GREEN_UP: begin
            g_raw = in_word.chroma;
            b_raw = in_word.second;
         end
         SECTOR_BLUE_LO: begin
            g_raw = in_word.second;
            b_raw = in_word.chroma;
         end
         SECTOR_BLUE_UP: begin
            r_raw = in_word.second;
            b_raw = in_word.chroma;
         end
         default: begin
            r_raw = in_word.chroma;
            b_raw = in_word.second;
         end
      endcase
      r_sum = {1'b0, r_raw} + {1'b0, in_word.offset};
      g_sum = {1'b0, g_raw} + {1'b0, in_word.offset};
      b_sum = {1'b0, b_raw} + {1'b0, in_word.offset};
      word_in.red   = r_sum[OUT_SH +: OUT_W];
      word_in.green = g_sum[OUT_SH +: OUT_W];
      word_in.blue  = b_sum[OUT_SH +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

/* rtl/core/hsv_to_rgb_fixed.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_fixed
// Integer HSV to RGB converter, three register stages, one word per cycle while rsp_stall is low.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    hue_raw, saturation, brightness
//   rsp      out        rsp_valid/stall    red_out, green_out, blue_out
//
// A word is accepted every cycle while rsp_stall is low; its result is registered
// in the front, mix and out stages in turn before it is valid on rsp.
// The slowest stage holds a 20x8 multiply.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// rsp_stall backs up through the stages; an empty stage keeps accepting,
// so req_stall rises only when all three stages hold a word.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_fixed (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [hsv_pkg::IN_W-1:0]   req_hue_raw,
   input  wire logic [hsv_pkg::IN_W-1:0]   req_saturation,
   input  wire logic [hsv_pkg::IN_W-1:0]   req_brightness,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [hsv_pkg::OUT_W-1:0]       rsp_red_out,
   output logic [hsv_pkg::OUT_W-1:0]       rsp_green_out,
   output logic [hsv_pkg::OUT_W-1:0]       rsp_blue_out
);
   import hsv_pkg::*;

   hsv_type   req_word;
   front_type front_word;
   mix_type   mix_word;
   rgb_type   rgb_word;
   logic      req_ready;
   logic      front_valid;
   logic      front_ready;
   logic      mix_valid;
   logic      mix_ready;

   assign req_word.hue_raw    = req_hue_raw;
   assign req_word.saturation = req_saturation;
   assign req_word.brightness = req_brightness;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_word  (mix_word)
   );

   hsv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_word   (mix_word),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_word  (rgb_word)
   );

   assign req_stall     = !req_ready;
   assign rsp_red_out   = rgb_word.red;
   assign rsp_green_out = rgb_word.green;
   assign rsp_blue_out  = rgb_word.blue;

endmodule

`default_nettype wire
